/* rtl/sorted_table_search_lerp_core_defines.svh */
`ifndef SORTED_TABLE_SEARCH_LERP_CORE_DEFINES_SVH
`define SORTED_TABLE_SEARCH_LERP_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/stsl_pkg.sv */
package stsl_pkg;

   // Table geometry.
   localparam int MAX_POINTS = 64;
   localparam int MIN_POINTS = 2;
   localparam int ADDR_W = $clog2(MAX_POINTS);

   // Field widths fixed by the item format.
   localparam int INDEX_W = 6;
   localparam int WL_W = 16;
   localparam int VAL_W = 24;
   localparam int NUM_POINTS_W = 7;
   localparam int SIDE_W = 2;
   localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RESET = NUM_POINTS_W'(2);

   // Divider and multiplier sizes: the quotient carries a 16-bit fraction.
   localparam int QUOT_W = 2 * WL_W;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int DELTA_W = VAL_W + 1;
   localparam int PROD_W = QUOT_W + 1 + DELTA_W;

   // Operation codes carried in the input item.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result kinds.
   localparam logic [SIDE_W-1:0] SIDE_INTERP = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_TOP = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_en;
      logic query_load;
      logic [ADDR_W-1:0] rd_addr;
      logic cap_lo;
      logic cap_hi;
      logic setup;
      logic div_step;
      logic mul;
      logic out_load;
      logic [SIDE_W-1:0] side;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic t_pos;
      logic out_free;
   } stat_type;

   // Index of the last table point in use, with the point count clamped.
   function automatic logic [ADDR_W-1:0] points_last(input logic [NUM_POINTS_W-1:0] num);
      int n;
      n = int'(num);
      if (n < MIN_POINTS) n = MIN_POINTS;
      if (n > MAX_POINTS) n = MAX_POINTS;
      return ADDR_W'(n - 1);
   endfunction

endpackage

/* rtl/sorted_table_search_lerp_core.sv */
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tdata: index, wavelength, value; tuser: op
// rsp      out        rsp_tvalid/rsp_tready   tdata: result value; tuser: clamp side
// csr      in         csr_valid/csr_ready     csr_data: number of points in use
//
// A query item scans the table one slot per cycle over the single table read port;
// an interpolated query then runs the 32-step divider. Reset is synchronous; the
// tables hold no reset value and need no clearing pass.
// A stalled result waits in the output register; the block stays busy on the
// finished query only until that register can take the new result.
module sorted_table_search_lerp_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // point_index[5:0], wavelength[21:6], point_value[45:22]
   input  logic [0:0]   req_tuser,   // op[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // result_value[23:0]
   output logic [1:0]   rsp_tuser,   // clamp_side[1:0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);

   stsl_pkg::cmd_type cmd;
   stsl_pkg::stat_type stat;
   logic [stsl_pkg::INDEX_W-1:0] req_index;
   logic [stsl_pkg::WL_W-1:0] req_wavelength;
   logic signed [stsl_pkg::VAL_W-1:0] req_value;
   logic signed [stsl_pkg::VAL_W-1:0] rsp_value;

   // Unpack the input item.
   assign req_index = req_tdata[5:0];
   assign req_wavelength = req_tdata[21:6];
   assign req_value = req_tdata[45:22];
   assign rsp_tdata = rsp_value;

   stsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   stsl_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_index      (req_index),
      .req_wavelength (req_wavelength),
      .req_value      (req_value),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_value      (rsp_value),
      .rsp_side       (rsp_tuser)
   );

endmodule

/* rtl/stsl_dpath.sv */
module stsl_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stsl_pkg::cmd_type                     cmd,
   output stsl_pkg::stat_type                    stat,
   input  logic [stsl_pkg::INDEX_W-1:0]          req_index,
   input  logic [stsl_pkg::WL_W-1:0]             req_wavelength,
   input  logic signed [stsl_pkg::VAL_W-1:0]     req_value,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [stsl_pkg::VAL_W-1:0]     rsp_value,
   output logic [stsl_pkg::SIDE_W-1:0]           rsp_side
);

   localparam int SUM_W = stsl_pkg::PROD_W - 16 + 1;
   localparam logic signed [SUM_W-1:0] SAT_MAX =
      (SUM_W'(1) <<< (stsl_pkg::VAL_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) <<< (stsl_pkg::VAL_W - 1));

   // Table memories.
   logic [stsl_pkg::WL_W-1:0] wl_mem_ff [stsl_pkg::MAX_POINTS];
   logic signed [stsl_pkg::VAL_W-1:0] val_mem_ff [stsl_pkg::MAX_POINTS];
   logic [stsl_pkg::WL_W-1:0] wl_rd_ff;
   logic signed [stsl_pkg::VAL_W-1:0] val_rd_ff;
   logic wr_ok;
   logic [stsl_pkg::ADDR_W-1:0] wr_addr;

   // Query registers.
   logic [stsl_pkg::WL_W-1:0] wl_q_ff;
   logic [stsl_pkg::WL_W-1:0] l_lo_ff;
   logic [stsl_pkg::WL_W-1:0] l_hi_ff;
   logic signed [stsl_pkg::VAL_W-1:0] v_lo_ff;
   logic signed [stsl_pkg::VAL_W-1:0] v_hi_ff;

   // Setup arithmetic.
   logic signed [stsl_pkg::WL_W:0] d_s;
   logic signed [stsl_pkg::WL_W:0] span_s;
   logic [stsl_pkg::WL_W-1:0] d_mag;
   logic [stsl_pkg::WL_W-1:0] span_mag;
   logic signed [stsl_pkg::DELTA_W-1:0] delta_in;
   logic signed [stsl_pkg::DELTA_W-1:0] delta_ff;

   // Divider.
   logic [stsl_pkg::QUOT_W-1:0] num_ff;
   logic [stsl_pkg::QUOT_W-1:0] num_in;
   logic [stsl_pkg::WL_W-1:0] den_ff;
   logic [stsl_pkg::WL_W-1:0] rem_ff;
   logic [stsl_pkg::WL_W-1:0] rem_in;
   logic [stsl_pkg::WL_W:0] rem_sh;
   logic rem_ge;

   // Multiplier and final sum.
   logic signed [stsl_pkg::PROD_W-1:0] prod_in;
   logic signed [stsl_pkg::PROD_W-1:0] prod_ff;
   logic signed [SUM_W-2:0] prod_sh;
   logic signed [SUM_W-1:0] base_ext;
   logic signed [SUM_W-1:0] add_ext;
   logic signed [SUM_W-1:0] sum_s;
   logic signed [stsl_pkg::VAL_W-1:0] result_in;

   // Output register.
   logic rsp_valid_ff;
   logic signed [stsl_pkg::VAL_W-1:0] rsp_value_ff;
   logic [stsl_pkg::SIDE_W-1:0] rsp_side_ff;

   // Writes beyond the table are dropped.
   assign wr_ok = cmd.wr_en && (int'(req_index) < stsl_pkg::MAX_POINTS);
   assign wr_addr = stsl_pkg::ADDR_W'(req_index);

   // Table write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         wl_mem_ff[wr_addr] <= req_wavelength;
         val_mem_ff[wr_addr] <= req_value;
      end
      wl_rd_ff <= wl_mem_ff[cmd.rd_addr];
      val_rd_ff <= val_mem_ff[cmd.rd_addr];
   end

   // Distance into the segment and segment span, both signed.
   assign d_s = $signed({1'b0, wl_q_ff}) - $signed({1'b0, l_lo_ff});
   assign span_s = $signed({1'b0, l_hi_ff}) - $signed({1'b0, l_lo_ff});
   assign d_mag = d_s[stsl_pkg::WL_W] ? stsl_pkg::WL_W'(-d_s) : d_s[stsl_pkg::WL_W-1:0];
   assign span_mag = span_s[stsl_pkg::WL_W] ? stsl_pkg::WL_W'(-span_s)
                                             : span_s[stsl_pkg::WL_W-1:0];
   assign delta_in = $signed({v_hi_ff[stsl_pkg::VAL_W-1], v_hi_ff})
                   - $signed({v_lo_ff[stsl_pkg::VAL_W-1], v_lo_ff});

   // One restoring step per cycle; the quotient shifts in behind the dividend.
   assign rem_sh = {rem_ff, num_ff[stsl_pkg::QUOT_W-1]};
   assign rem_ge = rem_sh >= {1'b0, den_ff};
   assign rem_in = rem_ge ? stsl_pkg::WL_W'(rem_sh - {1'b0, den_ff})
                          : rem_sh[stsl_pkg::WL_W-1:0];
   assign num_in = {num_ff[stsl_pkg::QUOT_W-2:0], rem_ge};

   assign prod_in = $signed({1'b0, num_ff}) * delta_ff;

   // Floor shift of the product, add to the lower value and saturate.
   assign prod_sh = prod_ff[stsl_pkg::PROD_W-1:16];
   assign base_ext = {{(SUM_W - stsl_pkg::VAL_W){v_lo_ff[stsl_pkg::VAL_W-1]}}, v_lo_ff};
   assign add_ext = (cmd.side == stsl_pkg::SIDE_INTERP) ? {prod_sh[SUM_W-2], prod_sh} : '0;
   assign sum_s = base_ext + add_ext;

   always_comb begin
      if (sum_s > SAT_MAX) begin
         result_in = SAT_MAX[stsl_pkg::VAL_W-1:0];
      end else if (sum_s < SAT_MIN) begin
         result_in = SAT_MIN[stsl_pkg::VAL_W-1:0];
      end else begin
         result_in = sum_s[stsl_pkg::VAL_W-1:0];
      end
   end

   // Working registers, loaded on controller commands.
   always_ff @(posedge clock) begin
      if (cmd.query_load) wl_q_ff <= req_wavelength;
      if (cmd.cap_lo) begin
         l_lo_ff <= wl_rd_ff;
         v_lo_ff <= val_rd_ff;
      end
      if (cmd.cap_hi) begin
         l_hi_ff <= wl_rd_ff;
         v_hi_ff <= val_rd_ff;
      end
      if (cmd.setup) begin
         num_ff <= {d_mag, {stsl_pkg::WL_W{1'b0}}};
         den_ff <= span_mag;
         rem_ff <= '0;
         delta_ff <= delta_in;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
      if (cmd.mul) prod_ff <= prod_in;
   end

   // Output register; a new result may load as the old one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_value_ff <= result_in;
         rsp_side_ff <= cmd.side;
      end
   end

   always_comb begin
      stat.hit = wl_rd_ff >= wl_q_ff;
      stat.t_pos = (d_s != '0) && (span_s != '0) &&
                   (d_s[stsl_pkg::WL_W] == span_s[stsl_pkg::WL_W]);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_side = rsp_side_ff;

endmodule

/* rtl/stsl_ctrl.sv */
`include "sorted_table_search_lerp_core_defines.svh"

module stsl_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_op,
   output logic                                  req_tready,
   input  logic                                  csr_valid,
   input  logic [stsl_pkg::NUM_POINTS_W-1:0]     csr_data,
   output logic                                  csr_ready,
   output stsl_pkg::cmd_type                     cmd,
   input  stsl_pkg::stat_type                    stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_SETUP,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [stsl_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [stsl_pkg::ADDR_W-1:0] lo_ff, lo_in;
   logic [stsl_pkg::ADDR_W-1:0] n_last_ff, n_last_in;
   logic [stsl_pkg::SIDE_W-1:0] side_ff, side_in;
   logic [stsl_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [stsl_pkg::NUM_POINTS_W-1:0] num_points_ff, num_points_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      lo_in = lo_ff;
      n_last_in = n_last_ff;
      side_in = side_ff;
      cnt_in = cnt_ff;
      num_points_in = csr_valid ? csr_data : num_points_ff;
      cmd = '0;
      cmd.rd_addr = idx_ff;
      cmd.side = side_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == stsl_pkg::OP_QUERY) begin
                  cmd.query_load = 1'b1;
                  n_last_in = stsl_pkg::points_last(num_points_ff);
                  state_in = ST_LOAD;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.rd_addr = '0;
            idx_in = '0;
            state_in = ST_SCAN;
         end
         // Walk the slots in order to the first one at or above the query, or to the last in use.
         ST_SCAN: begin
            if (stat.hit) begin
               lo_in = (idx_ff == '0) ? '0 : idx_ff - stsl_pkg::ADDR_W'(1);
               side_in = stsl_pkg::SIDE_INTERP;
               state_in = ST_FETCH0;
            end else if (idx_ff == n_last_ff) begin
               lo_in = n_last_ff;
               side_in = stsl_pkg::SIDE_TOP;
               state_in = ST_FETCH0;
            end else begin
               idx_in = idx_ff + stsl_pkg::ADDR_W'(1);
               cmd.rd_addr = idx_ff + stsl_pkg::ADDR_W'(1);
            end
         end
         // Read both ends of the segment.
         ST_FETCH0: begin
            cmd.rd_addr = lo_ff;
            state_in = ST_FETCH1;
         end
         ST_FETCH1: begin
            cmd.rd_addr = lo_ff + stsl_pkg::ADDR_W'(1);
            cmd.cap_lo = 1'b1;
            state_in = ST_FETCH2;
         end
         ST_FETCH2: begin
            cmd.cap_hi = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (side_ff == stsl_pkg::SIDE_TOP) begin
               state_in = ST_DONE;
            end else if (!stat.t_pos) begin
               side_in = stsl_pkg::SIDE_BOTTOM;
               state_in = ST_DONE;
            end else begin
               cmd.setup = 1'b1;
               cnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + stsl_pkg::DIV_CNT_W'(1);
            if (cnt_ff == stsl_pkg::DIV_CNT_W'(stsl_pkg::DIV_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         lo_ff <= '0;
         n_last_ff <= '0;
         side_ff <= stsl_pkg::SIDE_INTERP;
         cnt_ff <= '0;
         num_points_ff <= stsl_pkg::NUM_POINTS_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         lo_ff <= lo_in;
         n_last_ff <= n_last_in;
         side_ff <= side_in;
         cnt_ff <= cnt_in;
         num_points_ff <= num_points_in;
      end
   end

   `STSL_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_SCAN, idx_ff <= n_last_ff, "scan index past last point")
   `STSL_ASSERT_NOW(a_fetch_in_range, clock, reset, state_ff == ST_FETCH0, lo_ff <= n_last_ff, "segment start past last point")
   `STSL_ASSERT_NEXT(a_query_starts, clock, reset, req_tvalid && req_tready && (req_op == stsl_pkg::OP_QUERY), state_ff == ST_LOAD, "query item did not start a scan")
   `STSL_ASSERT_NOW(a_load_when_free, clock, reset, cmd.out_load, stat.out_free, "result loaded over a pending one")

endmodule

/* test/table_lerp_checker.sv */
// Watches the three channels of the interpolation core, keeps its own copy of the
// point table and the point count, predicts the result of every query and compares
// each returned item with the oldest prediction.
module table_lerp_checker
   import stsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [6:0]  csr_data,
   output int          mismatch_count,
   output int          lerp_outstanding
);

   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [SIDE_W-1:0] side;
   } lerp_result_type;

   localparam longint VALUE_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
   localparam longint VALUE_MIN = -(longint'(1) <<< (VAL_W - 1));

   // Shadow of the point table and of the point count register.
   logic [WL_W-1:0]         wl_table [MAX_POINTS];
   logic signed [VAL_W-1:0] val_table [MAX_POINTS];
   logic [NUM_POINTS_W-1:0] active_points;

   // Predicted results of queries that have been accepted but not yet returned.
   lerp_result_type expected_lerp [$];

   // Finds the bracketing points of a query wavelength and interpolates between them.
   function automatic lerp_result_type interpolate_query(input logic [WL_W-1:0] query_wl);
      int              n;
      int              slot;
      int              lo;
      int              k;
      longint          span;
      longint          offset;
      longint          frac;
      longint          delta;
      longint          acc;
      lerp_result_type r;
      n = int'(active_points);
      if (n < MIN_POINTS) n = MIN_POINTS;
      if (n > MAX_POINTS) n = MAX_POINTS;
      // First slot whose wavelength is at or above the query, or n if none is.
      slot = n;
      for (k = n - 1; k >= 0; k--) begin
         if (wl_table[k] >= query_wl) slot = k;
      end
      lo = (slot == 0) ? 0 : slot - 1;
      if (lo >= n - 1) begin
         acc = longint'(val_table[n-1]);
         r.side = SIDE_TOP;
      end else begin
         span = longint'(wl_table[lo+1]) - longint'(wl_table[lo]);
         offset = longint'(query_wl) - longint'(wl_table[lo]);
         // The fraction has 16 bits and truncates toward zero; a flat span gives zero.
         frac = (span == 0) ? 0 : (offset * 65536) / span;
         if (frac <= 0) begin
            acc = longint'(val_table[0]);
            r.side = SIDE_BOTTOM;
         end else begin
            delta = longint'(val_table[lo+1]) - longint'(val_table[lo]);
            acc = longint'(val_table[lo]) + ((frac * delta) >>> 16);
            r.side = SIDE_INTERP;
         end
      end
      if (acc > VALUE_MAX) acc = VALUE_MAX;
      if (acc < VALUE_MIN) acc = VALUE_MIN;
      r.value = acc[VAL_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      lerp_result_type want;
      logic [WL_W-1:0] item_wl;
      int new_fails;
      new_fails = 0;
      if (reset) begin
         active_points = NUM_POINTS_RESET;
         expected_lerp.delete();
         mismatch_count <= 0;
      end else begin
         // Returned items are matched first, so a query accepted in the same cycle
         // is never paired with the result it has not produced yet.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lerp.size() == 0) begin
               $display("%0t: unexpected result value %h side %0d", $time, rsp_tdata, rsp_tuser);
               new_fails++;
            end else begin
               want = expected_lerp.pop_front();
               if (rsp_tdata !== want.value) begin
                  $display("%0t: result_value expected %h got %h",
                           $time, want.value, rsp_tdata);
                  new_fails++;
               end
               if (rsp_tuser !== want.side) begin
                  $display("%0t: clamp_side expected %0d got %0d",
                           $time, want.side, rsp_tuser);
                  new_fails++;
               end
            end
         end
         if (csr_valid && csr_ready) active_points = csr_data;
         // A write stores a point; a query is predicted against the table as it stands.
         if (req_tvalid && req_tready) begin
            item_wl = req_tdata[INDEX_W +: WL_W];
            if (req_tuser[0] == OP_WRITE) begin
               wl_table[req_tdata[INDEX_W-1:0]] = item_wl;
               val_table[req_tdata[INDEX_W-1:0]] = req_tdata[INDEX_W+WL_W +: VAL_W];
            end else begin
               expected_lerp.push_back(interpolate_query(item_wl));
            end
         end
         mismatch_count <= mismatch_count + new_fails;
      end
      lerp_outstanding <= expected_lerp.size();
   end

endmodule

/* test/tb_top.sv */
// Drives table writes, queries and point count changes into the interpolation core,
// with bursty input and a stalling result side; the checker does the comparison.
module tb_top;
   import stsl_pkg::*;

   localparam int PHASES = 12;
   localparam int ITEMS_PER_PHASE = 95;
   // Longest query: a scan to the last of 64 slots plus the divider, with margin.
   localparam int SETTLE_CYCLES = 128;
   localparam int LONG_HOLD = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;     // point_index[5:0], wavelength[21:6], point_value[45:22]
   logic [0:0]  req_tuser = '0;     // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // result_value[23:0]
   logic [1:0]  rsp_tuser;         // clamp_side[1:0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   int mismatch_count;
   int lerp_outstanding;

   // Stimulus bookkeeping: table wavelengths as written, burst state, hold-off requests.
   logic [WL_W-1:0] stim_wl [MAX_POINTS];
   int burst_left = 0;
   int gap_max = 4;
   int hold_tickets = 0;

   sorted_table_search_lerp_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   table_lerp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .lerp_outstanding (lerp_outstanding)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   // Sends one item, opening a new burst with a random gap when the old one is used up.
   task automatic send_item(input logic op, input logic [INDEX_W-1:0] slot,
                            input logic [WL_W-1:0] wl, input logic [VAL_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(16, 1);
         gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, val, wl, slot};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_WRITE) stim_wl[slot] = wl;
   endtask

   // Stops offering items and waits until every predicted result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lerp_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_points_cfg(input logic [NUM_POINTS_W-1:0] count);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Point values lean on the two extremes now and then.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(7, 0))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Writes slots 0..count-1 with ascending wavelengths, some spans flat, some wide.
   task automatic fill_table(input int count);
      int base;
      int step_max;
      int step;
      int wl;
      int slot;
      base = $urandom_range(2000, 0);
      step_max = (65535 - base) / count;
      wl = base;
      for (slot = 0; slot < count; slot++) begin
         send_item(OP_WRITE, INDEX_W'(slot), WL_W'(wl), pick_value());
         case ($urandom_range(9, 0))
            0: step = 0;
            1: step = step_max;
            default: step = $urandom_range(step_max, 1);
         endcase
         wl = wl + step;
      end
   endtask

   // Mostly queries around the stored points; the writes mostly keep the order,
   // a few land outside the active slots and a few scramble it.
   task automatic random_item(input int count);
      int pick;
      int k;
      int hi;
      logic [WL_W-1:0] wl;
      pick = $urandom_range(99, 0);
      k = $urandom_range(count - 1, 0);
      hi = (k < count - 1) ? k + 1 : k;
      if (pick < 70) begin
         case ($urandom_range(5, 0))
            0: wl = stim_wl[k];
            1, 2: wl = WL_W'($urandom_range(stim_wl[hi], stim_wl[k]));
            3: wl = stim_wl[k] + WL_W'($urandom_range(40, 0)) - 16'd20;
            4: wl = WL_W'($urandom);
            default: wl = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
         endcase
         send_item(OP_QUERY, INDEX_W'($urandom), wl, VAL_W'($urandom));
      end else if (pick < 88) begin
         wl = WL_W'($urandom_range(k > 0 ? stim_wl[k-1] : 0,
                                   k < count - 1 ? stim_wl[k+1] : 65535));
         send_item(OP_WRITE, INDEX_W'(k), wl, pick_value());
      end else if (pick < 95 && count < MAX_POINTS) begin
         send_item(OP_WRITE, INDEX_W'($urandom_range(MAX_POINTS - 1, count)),
                   WL_W'($urandom), pick_value());
      end else begin
         send_item(OP_WRITE, INDEX_W'($urandom), WL_W'($urandom), pick_value());
      end
   endtask

   // Result side: cycles through several stall patterns and honors long hold-offs.
   initial begin : result_sink
      int cyc;
      int hold_left;
      int holds_served;
      logic ready;
      cyc = 0;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_tickets > holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            case ((cyc / 512) % 4)
               0: ready = 1'b1;
               1: ready = ($urandom_range(3, 0) != 0);
               2: ready = ((cyc % 7) < 3);
               default: ready = $urandom_range(1, 0);
            endcase
         end
         rsp_tready <= ready;
      end
   end

   // Ends the run when no item moves on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int item;
      int n_eff;
      logic [NUM_POINTS_W-1:0] phase_points [PHASES];
      phase_points = '{7'd2, 7'd64, 7'd5, 7'd1, 7'd127, 7'd17, 7'd0, 7'd33, 7'd64,
                       7'd3, 7'd0, 7'd0};
      phase_points[10] = NUM_POINTS_W'($urandom_range(127, 0));
      phase_points[11] = NUM_POINTS_W'($urandom_range(64, 2));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items with the reset point count of two.
      send_item(OP_WRITE, 6'd0, 16'd16, 24'h800000);
      send_item(OP_WRITE, 6'd1, 16'hFFFF, 24'h7FFFFF);
      // Below the bottom, on the bottom point, on the top point, and midway.
      send_item(OP_QUERY, 6'd0, 16'd0, 24'h000000);
      send_item(OP_QUERY, 6'd0, 16'd16, 24'h000000);
      send_item(OP_QUERY, 6'd0, 16'hFFFF, 24'h000000);
      send_item(OP_QUERY, 6'd63, 16'h8000, 24'hFFFFFF);
      // Two points at the same wavelength: a flat span.
      send_item(OP_WRITE, 6'd1, 16'd16, 24'h123456);
      send_item(OP_QUERY, 6'd0, 16'd16, 24'h000000);
      send_item(OP_QUERY, 6'd0, 16'd17, 24'h000000);
      send_item(OP_QUERY, 6'd0, 16'd10, 24'h000000);
      // Descending points: the fraction exceeds one and the sum saturates both ways.
      send_item(OP_WRITE, 6'd0, 16'd100, 24'h000000);
      send_item(OP_WRITE, 6'd1, 16'd50, 24'h7FFFFF);
      send_item(OP_QUERY, 6'd0, 16'd20, 24'h000000);
      send_item(OP_WRITE, 6'd1, 16'd50, 24'h800000);
      send_item(OP_QUERY, 6'd0, 16'd20, 24'h000000);
      send_item(OP_QUERY, 6'd0, 16'd80, 24'h000000);
      send_item(OP_QUERY, 6'd0, 16'd200, 24'h000000);
      // A write to the last slot, outside the points in use.
      send_item(OP_WRITE, 6'd63, 16'hFFFF, 24'hFFFFFF);
      send_item(OP_WRITE, 6'd0, 16'd0, 24'h000000);
      send_item(OP_WRITE, 6'd1, 16'hFFFF, 24'h000001);
      send_item(OP_QUERY, 6'd0, 16'hFFFE, 24'h000000);

      // Random phases, each with its own point count and a freshly ordered table.
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_points_cfg(phase_points[phase]);
         n_eff = int'(phase_points[phase]);
         if (n_eff < MIN_POINTS) n_eff = MIN_POINTS;
         if (n_eff > MAX_POINTS) n_eff = MAX_POINTS;
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(12, 2);
         fill_table(n_eff);
         // Block the result side for a long stretch while queries keep coming.
         if (phase == 1 || phase == 8) hold_tickets++;
         for (item = 0; item < ITEMS_PER_PHASE; item++) random_item(n_eff);
      end

      drain_results();
      if (mismatch_count == 0 && lerp_outstanding == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
